// File: hw/rtl/mhsi_pkg.sv
// Shared types, widths and constants of the magnetometer iron calibration block.
package mhsi_pkg;

    localparam int GAIN_FRAC_BITS = 16;

    localparam int W_AXIS  = 16;
    localparam int W_HALF  = 15;
    localparam int W_TOTAL = 17;
    localparam int W_DEN   = 17;
    localparam int W_OSUM  = 20;
    localparam int W_GSUM  = 28;
    localparam int W_GAIN  = 24;
    localparam int W_SPW   = 16;
    localparam int W_SCNT  = W_SPW + 1;
    localparam int W_WC    = 4;
    localparam int W_CFG_IDX  = 2;
    localparam int W_CFG_DATA = 16;
    localparam int W_NUM  = (W_TOTAL + GAIN_FRAC_BITS > W_GSUM) ?
                            (W_TOTAL + GAIN_FRAC_BITS) : W_GSUM;
    localparam int W_DCNT = $clog2(W_NUM + 1);
    localparam int W_IDX  = 3;

    localparam logic [W_CFG_IDX-1:0] CFG_SPW = 2'd0;
    localparam logic [W_CFG_IDX-1:0] CFG_WC  = 2'd1;

    localparam logic [W_SPW-1:0] SPW_RESET = 16'd1000;
    localparam logic [W_WC-1:0]  WC_RESET  = 4'd3;

    localparam logic signed [W_AXIS-1:0] AXIS_LO = -16'sd32767;
    localparam logic signed [W_AXIS-1:0] AXIS_HI = 16'sd32767;
    localparam logic [W_GAIN-1:0] GAIN_MAX = {W_GAIN{1'b1}};

    // Work item indexes: axes 0..2 for gain terms, 0..5 for the final averages.
    localparam logic [W_IDX-1:0] IDX_FIRST     = 3'd0;
    localparam logic [W_IDX-1:0] IDX_LAST_AXIS = 3'd2;
    localparam logic [W_IDX-1:0] IDX_FIRST_GAIN = 3'd3;
    localparam logic [W_IDX-1:0] IDX_LAST_FIN  = 3'd5;

    typedef struct packed {
        logic signed [W_AXIS-1:0] sample_x;
        logic signed [W_AXIS-1:0] sample_y;
        logic signed [W_AXIS-1:0] sample_z;
    } t_sample;

    typedef struct packed {
        logic signed [W_AXIS-1:0] offset_x;
        logic signed [W_AXIS-1:0] offset_y;
        logic signed [W_AXIS-1:0] offset_z;
        logic [W_GAIN-1:0]        gain_x;
        logic [W_GAIN-1:0]        gain_y;
        logic [W_GAIN-1:0]        gain_z;
        logic                     degenerate;
    } t_result;

    typedef struct packed {
        logic             close;
        logic             div_start;
        logic             fin;
        logic             gain_store;
        logic             fin_store;
        logic             win_end;
        logic             emit;
        logic [W_IDX-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic win_last;
        logic run_last;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

// File: hw/rtl/mhsi_sample_if.sv
// Handshake channel carrying one raw three-axis sample.
interface mhsi_sample_if;
    import mhsi_pkg::*;
    logic    valid;
    logic    ready;
    t_sample data;
    modport src (output valid, output data, input ready);
    modport snk (input valid, input data, output ready);
endinterface

// File: hw/rtl/mhsi_result_if.sv
// Handshake channel carrying one calibration result.
interface mhsi_result_if;
    import mhsi_pkg::*;
    logic    valid;
    logic    ready;
    t_result data;
    modport src (output valid, output data, input ready);
    modport snk (input valid, input data, output ready);
endinterface

// File: hw/rtl/mhsi_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module mhsi_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [mhsi_pkg::W_NUM-1:0] i_num,
    input  logic [mhsi_pkg::W_DEN-1:0] i_den,
    output logic                      o_done,
    output logic [mhsi_pkg::W_NUM-1:0] o_quot
);
    import mhsi_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [W_DCNT-1:0] r_cnt;
    logic [W_NUM-1:0]  r_num;
    logic [W_DEN-1:0]  r_rem;
    logic [W_DEN-1:0]  r_den;
    logic [W_DEN:0]    trial;
    logic [W_DEN:0]    diff;
    logic              ge;

    assign trial = {r_rem, r_num[W_NUM-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= W_DCNT'(W_NUM);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == W_DCNT'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[W_NUM-2:0], ge};
            r_rem <= ge ? diff[W_DEN-1:0] : trial[W_DEN-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy))
        else $error("divider finished without having been busy");

endmodule

// File: hw/rtl/mhsi_dp.sv
// Datapath: min/max tracking, window sums, shared divider and result register.
module mhsi_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_acc,
    input  mhsi_pkg::t_sample              i_sample,
    input  logic                           i_cfg_we,
    input  logic [mhsi_pkg::W_CFG_IDX-1:0]  i_cfg_idx,
    input  logic [mhsi_pkg::W_CFG_DATA-1:0] i_cfg_data,
    input  mhsi_pkg::t_cmd                 i_cmd,
    input  logic                           i_out_ready,
    output mhsi_pkg::t_stat                o_stat,
    output logic                           o_out_valid,
    output mhsi_pkg::t_result              o_out
);
    import mhsi_pkg::*;

    logic [W_SPW-1:0]         r_spw;
    logic [W_WC-1:0]          r_wc;
    logic signed [W_AXIS-1:0] r_max [3];
    logic signed [W_AXIS-1:0] r_min [3];
    logic [W_SCNT-1:0]        r_scnt;
    logic [W_WC-1:0]          r_wcnt;
    logic signed [W_OSUM-1:0] r_osum [3];
    logic [W_GSUM-1:0]        r_gsum [3];
    logic                     r_degen;
    logic [W_HALF-1:0]        r_half [3];
    logic [W_TOTAL-1:0]       r_total;
    logic signed [W_AXIS-1:0] r_roff [3];
    logic [W_GAIN-1:0]        r_rgain [3];
    logic                     r_out_vld;
    t_result                  r_out;

    logic signed [W_AXIS-1:0] smp [3];
    logic signed [W_AXIS:0]   msum [3];
    logic signed [W_AXIS:0]   mid [3];
    logic [W_AXIS:0]          rng [3];
    logic [W_HALF-1:0]        half_c [3];
    logic [W_TOTAL-1:0]       total_c;
    logic                     zero_c;
    logic [W_SPW-1:0]         spw_eff;
    logic [W_WC-1:0]          wc_eff;
    logic [1:0]               ax;
    logic [W_NUM-1:0]         num;
    logic [W_DEN-1:0]         den;
    logic [W_OSUM-1:0]        omag;
    logic                     div_done;
    logic [W_NUM-1:0]         quot;
    logic [W_GAIN-1:0]        term;
    logic [W_OSUM-1:0]        qo;

    assign smp[0] = i_sample.sample_x;
    assign smp[1] = i_sample.sample_y;
    assign smp[2] = i_sample.sample_z;

    assign spw_eff = (r_spw == '0) ? W_SPW'(1) : r_spw;
    assign wc_eff  = (r_wc == '0) ? W_WC'(1) : r_wc;

    always_comb begin
        total_c = '0;
        zero_c  = 1'b0;
        for (int a = 0; a < 3; a++) begin
            msum[a]   = {r_max[a][W_AXIS-1], r_max[a]} + {r_min[a][W_AXIS-1], r_min[a]};
            // Midpoint rounded toward zero.
            mid[a]    = $signed(msum[a] + {{W_AXIS{1'b0}}, msum[a][W_AXIS]}) >>> 1;
            rng[a]    = {r_max[a][W_AXIS-1], r_max[a]} - {r_min[a][W_AXIS-1], r_min[a]};
            half_c[a] = rng[a][W_HALF:1];
            total_c   = total_c + W_TOTAL'(half_c[a]);
            zero_c    = zero_c | (half_c[a] == '0);
        end
    end

    // Operand selection for the shared divider.
    assign ax = (i_cmd.idx >= IDX_FIRST_GAIN) ? 2'(i_cmd.idx - IDX_FIRST_GAIN)
                                               : i_cmd.idx[1:0];
    assign omag = r_osum[ax][W_OSUM-1] ? W_OSUM'(-r_osum[ax]) : W_OSUM'(r_osum[ax]);

    always_comb begin
        if (!i_cmd.fin) begin
            num = W_NUM'(r_total) << GAIN_FRAC_BITS;
            den = (r_half[ax] == '0) ? W_DEN'(1)
                : (W_DEN'({r_half[ax], 1'b0}) + W_DEN'(r_half[ax]));
        end else if (i_cmd.idx < IDX_FIRST_GAIN) begin
            num = W_NUM'(omag);
            den = W_DEN'(wc_eff);
        end else begin
            num = W_NUM'(r_gsum[ax]);
            den = W_DEN'(wc_eff);
        end
    end

    mhsi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (num),
        .i_den   (den),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    assign term = (r_half[ax] == '0) ? GAIN_MAX
                : (quot > W_NUM'(GAIN_MAX)) ? GAIN_MAX : quot[W_GAIN-1:0];
    assign qo   = quot[W_OSUM-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spw     <= SPW_RESET;
            r_wc      <= WC_RESET;
            r_scnt    <= '0;
            r_wcnt    <= '0;
            r_degen   <= 1'b0;
            r_out_vld <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                r_max[a]  <= AXIS_LO;
                r_min[a]  <= AXIS_HI;
                r_osum[a] <= '0;
                r_gsum[a] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SPW: r_spw <= i_cfg_data[W_SPW-1:0];
                    CFG_WC:  r_wc  <= i_cfg_data[W_WC-1:0];
                    default: ;
                endcase
            end
            if (i_acc) begin
                r_scnt <= r_scnt + 1'b1;
                for (int a = 0; a < 3; a++) begin
                    if (smp[a] > r_max[a]) r_max[a] <= smp[a];
                    if (smp[a] < r_min[a]) r_min[a] <= smp[a];
                end
            end
            if (i_cmd.close) begin
                for (int a = 0; a < 3; a++) begin
                    r_osum[a] <= r_osum[a] + W_OSUM'(mid[a]);
                end
                if (zero_c) r_degen <= 1'b1;
            end
            if (i_cmd.gain_store) begin
                r_gsum[ax] <= r_gsum[ax] + W_GSUM'(term);
            end
            if (i_cmd.win_end) begin
                r_scnt <= '0;
                r_wcnt <= r_wcnt + 1'b1;
                for (int a = 0; a < 3; a++) begin
                    r_max[a] <= AXIS_LO;
                    r_min[a] <= AXIS_HI;
                end
            end
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
                r_wcnt    <= '0;
                r_degen   <= 1'b0;
                for (int a = 0; a < 3; a++) begin
                    r_osum[a] <= '0;
                    r_gsum[a] <= '0;
                end
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.close) begin
            r_total <= total_c;
            for (int a = 0; a < 3; a++) begin
                r_half[a] <= half_c[a];
            end
        end
        if (i_cmd.fin_store) begin
            if (i_cmd.idx < IDX_FIRST_GAIN) begin
                r_roff[ax] <= r_osum[ax][W_OSUM-1] ? W_AXIS'(-qo) : W_AXIS'(qo);
            end else begin
                r_rgain[ax] <= quot[W_GAIN-1:0];
            end
        end
        if (i_cmd.emit) begin
            r_out.offset_x   <= r_roff[0];
            r_out.offset_y   <= r_roff[1];
            r_out.offset_z   <= r_roff[2];
            r_out.gain_x     <= r_rgain[0];
            r_out.gain_y     <= r_rgain[1];
            r_out.gain_z     <= r_rgain[2];
            r_out.degenerate <= r_degen;
        end
    end

    assign o_stat.win_last = (r_scnt + 1'b1) >= W_SCNT'(spw_eff);
    assign o_stat.run_last = ({1'b0, r_wcnt} + 1'b1) >= {1'b0, wc_eff};
    assign o_stat.div_done = div_done;
    assign o_stat.out_free = !r_out_vld || i_out_ready;
    assign o_out_valid     = r_out_vld;
    assign o_out           = r_out;

    a_emit_clears_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_wcnt == '0) && !r_degen && (r_osum[0] == '0)
                       && (r_gsum[0] == '0) && r_out_vld)
        else $error("run state not cleared after a result was issued");

endmodule

// File: hw/rtl/mhsi_ctrl.sv
// Controller state machine sequencing window close and final averaging.
module mhsi_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_acc,
    input  mhsi_pkg::t_stat i_stat,
    output logic            o_ready,
    output mhsi_pkg::t_cmd  o_cmd
);
    import mhsi_pkg::*;

    typedef enum logic [7:0] {
        S_RUN   = 8'b0000_0001,
        S_CLOSE = 8'b0000_0010,
        S_GDIV  = 8'b0000_0100,
        S_GWAIT = 8'b0000_1000,
        S_WEND  = 8'b0001_0000,
        S_FDIV  = 8'b0010_0000,
        S_FWAIT = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [W_IDX-1:0] r_idx, n_idx;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_ready = 1'b0;
        o_cmd   = '0;
        o_cmd.idx = r_idx;
        case (r_state)
            S_RUN: begin
                o_ready = 1'b1;
                if (i_acc && i_stat.win_last) n_state = S_CLOSE;
            end
            S_CLOSE: begin
                o_cmd.close = 1'b1;
                n_idx   = IDX_FIRST;
                n_state = S_GDIV;
            end
            S_GDIV: begin
                o_cmd.div_start = 1'b1;
                n_state = S_GWAIT;
            end
            S_GWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.gain_store = 1'b1;
                    if (r_idx == IDX_LAST_AXIS) begin
                        n_state = S_WEND;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_GDIV;
                    end
                end
            end
            S_WEND: begin
                o_cmd.win_end = 1'b1;
                if (i_stat.run_last) begin
                    n_idx   = IDX_FIRST;
                    n_state = S_FDIV;
                end else begin
                    n_state = S_RUN;
                end
            end
            S_FDIV: begin
                o_cmd.fin       = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state = S_FWAIT;
            end
            S_FWAIT: begin
                o_cmd.fin = 1'b1;
                if (i_stat.div_done) begin
                    o_cmd.fin_store = 1'b1;
                    if (r_idx == IDX_LAST_FIN) begin
                        n_state = S_EMIT;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_FDIV;
                    end
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_idx   <= IDX_FIRST;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    a_close_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && i_stat.win_last) |=> (r_state == S_CLOSE))
        else $error("window end not followed by close");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_LAST_FIN)
        else $error("work index out of range");

    a_emit_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.out_free)
        else $error("result issued over an untaken result");

endmodule

// File: hw/rtl/magnetometer_hard_soft_iron_calibration.sv
// Top level of the min/max hard- and soft-iron magnetometer calibration block.
//
// Samples arrive on i_sample, one three-axis reading per transfer; results leave on
// o_result, one per completed run of window_count windows.
// Within a window a sample is taken every cycle. The sample that closes a window
// stalls the input while the midpoints are added and the three gain terms are
// worked out on the shared bit-serial divider. At the end of a run the six averages
// pass through the same divider, and the result is loaded into the output register.
// The divider produces one quotient bit per cycle.
// The output register lets sampling continue while a result waits; only a second
// result that finds the first still untaken holds the block until that transfer.
// Configuration writes take effect at once and are meant for an idle block.
// Synchronous reset restores samples_per_window to 1000, window_count to 3, and
// clears the min/max, counters, sums and the output valid flag.
module magnetometer_hard_soft_iron_calibration (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mhsi_sample_if.snk                     i_sample,
    mhsi_result_if.src                     o_result,
    input  logic                           i_cfg_we,
    input  logic [mhsi_pkg::W_CFG_IDX-1:0]  i_cfg_idx,
    input  logic [mhsi_pkg::W_CFG_DATA-1:0] i_cfg_data
);
    import mhsi_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  ready;
    logic  acc;

    // A sample transfer completes only while the controller is tracking.
    assign acc            = i_sample.valid && ready;
    assign i_sample.ready = ready;

    mhsi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_stat  (stat),
        .o_ready (ready),
        .o_cmd   (cmd)
    );

    mhsi_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_sample    (i_sample.data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .i_out_ready (o_result.ready),
        .o_stat      (stat),
        .o_out_valid (o_result.valid),
        .o_out       (o_result.data)
    );

endmodule

// File: sim/tb.sv
// Self-checking testbench for the magnetometer hard- and soft-iron calibration block.
`timescale 1ns / 1ps

module tb;
    import mhsi_pkg::*;

    // Holds a cycle-free model of the calibration and the results it still owes.
    class calib_scoreboard;
        int unsigned      spw;
        int unsigned      wc;
        int               axis_hi[3];
        int               axis_lo[3];
        int unsigned      n_samples;
        int unsigned      n_windows;
        int               bias_acc[3];
        longint unsigned  scale_acc[3];
        bit               flat_seen;
        t_result          owed[$];
        int               errors;

        function new();
            spw    = SPW_RESET;
            wc     = WC_RESET;
            errors = 0;
            clear_run();
        endfunction

        function void clear_window();
            for (int a = 0; a < 3; a++) begin
                axis_hi[a] = -32767;
                axis_lo[a] = 32767;
            end
            n_samples = 0;
        endfunction

        function void clear_run();
            clear_window();
            for (int a = 0; a < 3; a++) begin
                bias_acc[a]  = 0;
                scale_acc[a] = 0;
            end
            n_windows = 0;
            flat_seen = 1'b0;
        endfunction

        function void write_reg(logic [W_CFG_IDX-1:0] idx, logic [W_CFG_DATA-1:0] data);
            if (idx == CFG_SPW) begin
                spw = data;
            end else if (idx == CFG_WC) begin
                wc = data[W_WC-1:0];
            end
        endfunction

        function void close_window();
            int              half[3];
            longint unsigned total;
            longint unsigned term;
            total = 0;
            for (int a = 0; a < 3; a++) begin
                bias_acc[a] += (axis_hi[a] + axis_lo[a]) / 2;
                half[a] = (axis_hi[a] - axis_lo[a]) / 2;
                total += half[a];
            end
            for (int a = 0; a < 3; a++) begin
                if (half[a] <= 0) begin
                    term      = GAIN_MAX;
                    flat_seen = 1'b1;
                end else begin
                    term = (total << GAIN_FRAC_BITS) / (3 * longint'(half[a]));
                    if (term > GAIN_MAX) begin
                        term = GAIN_MAX;
                    end
                end
                scale_acc[a] = (scale_acc[a] + term) & 64'hFFFF_FFFF;
            end
            clear_window();
        endfunction

        function void absorb_sample(t_sample s);
            int          v[3];
            int unsigned eff_spw;
            int unsigned eff_wc;
            t_result     r;
            eff_spw = (spw == 0) ? 1 : spw;
            eff_wc  = (wc == 0) ? 1 : wc;
            v[0] = s.sample_x;
            v[1] = s.sample_y;
            v[2] = s.sample_z;
            for (int a = 0; a < 3; a++) begin
                if (v[a] > axis_hi[a]) axis_hi[a] = v[a];
                if (v[a] < axis_lo[a]) axis_lo[a] = v[a];
            end
            n_samples = (n_samples + 1) & 32'h1FFFF;
            if (n_samples < eff_spw) return;
            close_window();
            n_windows++;
            if (n_windows < eff_wc) return;
            r.offset_x   = 16'(bias_acc[0] / int'(eff_wc));
            r.offset_y   = 16'(bias_acc[1] / int'(eff_wc));
            r.offset_z   = 16'(bias_acc[2] / int'(eff_wc));
            r.gain_x     = 24'(scale_acc[0] / eff_wc);
            r.gain_y     = 24'(scale_acc[1] / eff_wc);
            r.gain_z     = 24'(scale_acc[2] / eff_wc);
            r.degenerate = flat_seen;
            owed.push_back(r);
            clear_run();
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (owed.size() == 0) begin
                $error("result transfer with nothing outstanding: %p", got);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (got.offset_x !== want.offset_x) begin
                $error("offset_x: expected %0d, got %0d", want.offset_x, got.offset_x);
                errors++;
            end
            if (got.offset_y !== want.offset_y) begin
                $error("offset_y: expected %0d, got %0d", want.offset_y, got.offset_y);
                errors++;
            end
            if (got.offset_z !== want.offset_z) begin
                $error("offset_z: expected %0d, got %0d", want.offset_z, got.offset_z);
                errors++;
            end
            if (got.gain_x !== want.gain_x) begin
                $error("gain_x: expected %0d, got %0d", want.gain_x, got.gain_x);
                errors++;
            end
            if (got.gain_y !== want.gain_y) begin
                $error("gain_y: expected %0d, got %0d", want.gain_y, got.gain_y);
                errors++;
            end
            if (got.gain_z !== want.gain_z) begin
                $error("gain_z: expected %0d, got %0d", want.gain_z, got.gain_z);
                errors++;
            end
            if (got.degenerate !== want.degenerate) begin
                $error("degenerate: expected %0b, got %0b", want.degenerate,
                       got.degenerate);
                errors++;
            end
        endfunction
    endclass

    // The block stalls for a window close and then a run close; settling time before
    // a register write allows for both with margin.
    localparam int SETTLE_CYCLES = 400;
    // A quiet stretch longer than this means the block has hung.
    localparam int QUIET_LIMIT   = 5000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [W_CFG_IDX-1:0]  cfg_idx  = '0;
    logic [W_CFG_DATA-1:0] cfg_data = '0;

    mhsi_sample_if smp_if ();
    mhsi_result_if res_if ();

    calib_scoreboard sb = new();

    // While calm is set neither side idles, giving a long unbroken stretch.
    bit calm = 1'b0;
    int quiet_cycles = 0;

    // Per-phase field shape: a centre and spread per axis for well-formed sweeps.
    int centre[3];
    int spread[3];

    initial begin
        smp_if.valid = 1'b0;
        smp_if.data  = '0;
        res_if.ready = 1'b0;
    end

    magnetometer_hard_soft_iron_calibration i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (smp_if),
        .o_result   (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // The receiver stalls at random, except in the calm stretch.
    always @(negedge i_clk) begin
        res_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 27);
    end

    // Every accepted result is checked against the oldest outstanding prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            sb.check_result(res_if.data);
        end
    end

    // Watchdog on cycles where neither channel completes a transfer.
    always @(posedge i_clk) begin
        if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic logic signed [15:0] clip16(int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    // Offers one sample and returns once its transfer has happened.
    task automatic send_sample(t_sample s);
        while (!calm && $urandom_range(99) < 27) begin
            smp_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        smp_if.valid <= 1'b1;
        smp_if.data  <= s;
        do @(posedge i_clk); while (!(smp_if.valid && smp_if.ready));
        sb.absorb_sample(s);
        @(negedge i_clk);
    endtask

    task automatic send_xyz(int x, int y, int z);
        t_sample s;
        s.sample_x = clip16(x);
        s.sample_y = clip16(y);
        s.sample_z = clip16(z);
        send_sample(s);
    endtask

    // Holds the sender off until every predicted result has been taken.
    task automatic wait_drained();
        smp_if.valid <= 1'b0;
        @(negedge i_clk);
        while (sb.owed.size() != 0) @(negedge i_clk);
    endtask

    // Register writes happen only on a quiet block, after any close has finished.
    task automatic write_reg(logic [W_CFG_IDX-1:0] idx, logic [W_CFG_DATA-1:0] data);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_samples(int n);
        t_sample s;
        for (int a = 0; a < 3; a++) begin
            centre[a] = int'($urandom_range(60000)) - 30000;
            spread[a] = $urandom_range(4) == 0 ? 0 : $urandom_range(3000);
        end
        repeat (n) begin
            if ($urandom_range(9) < 7) begin
                // Well-formed sweep around a hard-iron centre.
                send_xyz(centre[0] + int'($urandom_range(2 * spread[0])) - spread[0],
                         centre[1] + int'($urandom_range(2 * spread[1])) - spread[1],
                         centre[2] + int'($urandom_range(2 * spread[2])) - spread[2]);
            end else begin
                s = t_sample'({16'($urandom), $urandom});
                s.sample_x = 16'($urandom);
                send_sample(s);
            end
        end
    endtask

    task automatic run_phase(int spw, int wc, int n);
        write_reg(CFG_SPW, 16'(spw));
        write_reg(CFG_WC, 16'(wc));
        random_samples(n);
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. Single-sample windows put every field extreme through.
        write_reg(CFG_SPW, 16'd1);
        write_reg(CFG_WC, 16'd1);
        send_xyz(32767, -32768, 0);
        send_xyz(-32768, 32767, -1);
        send_xyz(0, 0, 0);
        send_xyz(-32767, 32766, 1);
        // Two-sample windows: a tiny x range against wide y and z saturates the
        // x gain without flagging; a flat axis sets the flag.
        write_reg(CFG_SPW, 16'd2);
        send_xyz(0, -1000, -1000);
        send_xyz(2, 1000, 1000);
        send_xyz(-32768, -32768, 5);
        send_xyz(32767, 32767, 5);
        send_xyz(100, 200, 300);
        send_xyz(300, 600, 900);
        // Two windows averaged, with negative midpoints that truncate toward zero.
        write_reg(CFG_WC, 16'd2);
        send_xyz(-3, -7, -9);
        send_xyz(0, 0, 0);
        send_xyz(-5, -1, -20000);
        send_xyz(4, 3, 20001);
        // Zero in both registers acts as one.
        write_reg(CFG_SPW, 16'd0);
        write_reg(CFG_WC, 16'd0);
        send_xyz(12, -12, 7);
        send_xyz(-9, 9, 7);
        // Writes beyond the register list are ignored.
        write_reg(2'd2, 16'hFFFF);
        write_reg(2'd3, 16'h0000);
        send_xyz(1, 2, 3);
        // Lowering the window mid-window closes it on the next sample.
        write_reg(CFG_SPW, 16'd10);
        send_xyz(-50, 50, 0);
        send_xyz(50, -50, 0);
        send_xyz(70, 10, -30);
        write_reg(CFG_SPW, 16'd2);
        send_xyz(0, 0, 0);

        // Random part across several settings, the window count extremes among them.
        run_phase(3, 2, 150);
        run_phase(1, 1, 100);
        run_phase(0, 0, 60);
        run_phase(5, 15, 200);
        calm = 1'b1;
        run_phase(7, 8, 200);
        calm = 1'b0;
        run_phase(2, 4, 150);
        write_reg(CFG_SPW, 16'd4);
        write_reg(CFG_WC, 16'd3);
        random_samples(70);
        wait_drained();
        random_samples(80);
        run_phase(300, 2, 620);
        // Lowering the window count with windows already counted ends the run early.
        write_reg(CFG_SPW, 16'd6);
        write_reg(CFG_WC, 16'd8);
        random_samples(33);
        write_reg(CFG_WC, 16'd2);
        random_samples(70);
        // One long single-window run.
        run_phase(150, 1, 150);

        smp_if.valid <= 1'b0;
        while (sb.owed.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule

// File: magnetometer_hard_soft_iron_calibration.f
hw/rtl/mhsi_pkg.sv
hw/rtl/mhsi_sample_if.sv
hw/rtl/mhsi_result_if.sv
hw/rtl/mhsi_div.sv
hw/rtl/mhsi_dp.sv
hw/rtl/mhsi_ctrl.sv
hw/rtl/magnetometer_hard_soft_iron_calibration.sv
sim/tb.sv
